// File: design/valve_max_on_time_lockout_assert.svh
// Assertion macros for the valve on-time limiter.
`ifndef VALVE_MAX_ON_TIME_LOCKOUT_ASSERT_SVH
`define VALVE_MAX_ON_TIME_LOCKOUT_ASSERT_SVH
`ifndef ASSERT_OFF
`define VMOL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vmol assertion failed");
`define VMOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vmol assertion failed");
`else
`define VMOL_ASSERT_NOW(label, clk, rst, ante, cons)
`define VMOL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/vmol_pkg.sv
// Types, constants and helpers shared by the valve on-time limiter.
`timescale 1ns / 1ps
package vmol_pkg;

  localparam int COUNT_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_ON_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT = 1'd1;

  localparam logic [COUNT_W-1:0] ON_LIMIT_RESET = 16'd1000;
  localparam logic [COUNT_W-1:0] LOCKOUT_RESET = 16'd5000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    count_t on_limit;
    count_t lockout;
  } vmol_cfg_t;

  typedef struct packed {
    logic valve;
    logic locked;
  } vmol_chan_st_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + count_t'(1);
  endfunction

endpackage

// File: design/vmol_tick_if.sv
// Valid/ready channel interfaces: tick input and result output.
`timescale 1ns / 1ps
interface vmol_tick_if #(parameter int CHANNELS = 3);
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] pressed_mask;

  modport source (output valid, output pressed_mask, input ready);
  modport sink (input valid, input pressed_mask, output ready);
endinterface

interface vmol_result_if #(parameter int CHANNELS = 3);
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] valve_mask;
  logic [CHANNELS-1:0] locked_mask;

  modport source (output valid, output valve_mask, output locked_mask, input ready);
  modport sink (input valid, input valve_mask, input locked_mask, output ready);
endinterface

// File: design/valve_max_on_time_lockout.sv
// Top level of the valve on-time limiter with lockout.
//
//   port        dir   payload                        meaning
//   tick_in     sink  pressed_mask[CHANNELS]         one tick of button states
//   result_out  src   valve_mask, locked_mask        valve and lockout after tick
//   cfg_*       in    cfg_index, cfg_data[15:0]      on_limit / lockout writes
//
// One tick per cycle; the result is registered and shows in the cycle after the
// transaction. tick_in.ready drops only while a result waits with
// result_out.ready low. Synchronous reset clears all channel state and loads
// on_limit 1000 and lockout 5000.
`timescale 1ns / 1ps
`include "valve_max_on_time_lockout_assert.svh"
module valve_max_on_time_lockout
  import vmol_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  vmol_tick_if.sink              tick_in,
  vmol_result_if.source          result_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  vmol_cfg_t           cfg;
  logic                out_valid;
  logic [CHANNELS-1:0] valve_mask;
  logic [CHANNELS-1:0] locked_mask;
  logic [CHANNELS-1:0] valve_mask_next;
  logic [CHANNELS-1:0] locked_mask_next;
  logic                step;

  assign tick_in.ready = !out_valid || result_out.ready;
  assign step = tick_in.valid && tick_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_limit <= ON_LIMIT_RESET;
      cfg.lockout  <= LOCKOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_LIMIT: cfg.on_limit <= cfg_data;
        REG_LOCKOUT:  cfg.lockout  <= cfg_data;
        default:      ;
      endcase
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    vmol_chan_st_t st_next;

    vmol_chan u_chan (
      .clk     (clk),
      .rst     (rst),
      .step    (step),
      .press   (tick_in.pressed_mask[c]),
      .cfg     (cfg),
      .st_next (st_next)
    );

    assign valve_mask_next[c]  = st_next.valve;
    assign locked_mask_next[c] = st_next.locked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      valve_mask  <= valve_mask_next;
      locked_mask <= locked_mask_next;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.valve_mask  = valve_mask;
  assign result_out.locked_mask = locked_mask;

  // a locked channel never has its valve open
  `VMOL_ASSERT_NOW(a_no_open_while_locked, clk, rst, out_valid,
                   (valve_mask & locked_mask) == '0)
  `VMOL_ASSERT_NEXT(a_result_follows_tick, clk, rst, step, out_valid)
  `VMOL_ASSERT_NOW(a_stall_only_on_backpressure, clk, rst, !tick_in.ready,
                   out_valid && !result_out.ready)
  `VMOL_ASSERT_NEXT(a_on_limit_write, clk, rst, cfg_we && (cfg_index == REG_ON_LIMIT),
                    cfg.on_limit == $past(cfg_data))

endmodule

// File: design/vmol_chan.sv
// One channel: valve and lockout state with saturating tick counters.
`timescale 1ns / 1ps
module vmol_chan
  import vmol_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          press,
  input  vmol_cfg_t     cfg,
  output vmol_chan_st_t st_next
);

  logic   valve_open;
  logic   lock_active;
  count_t open_count;
  count_t lock_count;

  logic   valve_open_next;
  logic   lock_active_next;
  count_t open_count_next;
  count_t lock_count_next;

  always_comb begin
    count_t oc;
    count_t lc;
    logic   vo;
    logic   la;
    oc = valve_open ? sat_inc(open_count) : open_count;
    lc = lock_active ? sat_inc(lock_count) : lock_count;
    vo = valve_open;
    la = lock_active;
    if (la && (lc > cfg.lockout)) begin
      la = 1'b0;
      lc = '0;
    end
    if (press) begin
      if (!la && !vo) begin
        vo = 1'b1;
        oc = '0;
      end
      if (vo && (oc > cfg.on_limit)) begin
        vo = 1'b0;
        oc = '0;
        la = 1'b1;
        lc = '0;
      end
    end else begin
      vo = 1'b0;
      oc = '0;
    end
    valve_open_next  = vo;
    lock_active_next = la;
    open_count_next  = oc;
    lock_count_next  = lc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valve_open  <= 1'b0;
      lock_active <= 1'b0;
      open_count  <= '0;
      lock_count  <= '0;
    end else if (step) begin
      valve_open  <= valve_open_next;
      lock_active <= lock_active_next;
      open_count  <= open_count_next;
      lock_count  <= lock_count_next;
    end
  end

  assign st_next.valve  = valve_open_next;
  assign st_next.locked = lock_active_next;

endmodule

// File: test/vmol_result_check.sv
// Checker for the valve on-time limiter: predicts the masks of each tick and compares results.
`timescale 1ns / 1ps
module vmol_result_check
  import vmol_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  vmol_tick_if                   tick,
  vmol_result_if                 result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     outstanding,
  output int                     lock_hits
);

  typedef struct packed {
    logic [CHANNELS-1:0] valve_mask;
    logic [CHANNELS-1:0] locked_mask;
  } masks_t;

  vmol_cfg_t           limits;
  logic [CHANNELS-1:0] open_now;
  logic [CHANNELS-1:0] locked_now;
  count_t              open_ticks [CHANNELS];
  count_t              lock_ticks [CHANNELS];
  masks_t              expected_masks [$];

  function automatic count_t bump(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic masks_t step_channels(input logic [CHANNELS-1:0] pressed);
    masks_t m;
    for (int c = 0; c < CHANNELS; c++) begin
      if (open_now[c]) open_ticks[c] = bump(open_ticks[c]);
      if (locked_now[c]) lock_ticks[c] = bump(lock_ticks[c]);
      if (locked_now[c] && lock_ticks[c] > limits.lockout) begin
        locked_now[c] = 1'b0;
        lock_ticks[c] = '0;
      end
      if (pressed[c]) begin
        if (!locked_now[c] && !open_now[c]) begin
          open_now[c] = 1'b1;
          open_ticks[c] = '0;
        end
        // held past the limit: forced close, lockout starts
        if (open_now[c] && open_ticks[c] > limits.on_limit) begin
          open_now[c] = 1'b0;
          open_ticks[c] = '0;
          locked_now[c] = 1'b1;
          lock_ticks[c] = '0;
        end
      end else begin
        open_now[c] = 1'b0;
        open_ticks[c] = '0;
      end
    end
    m.valve_mask = open_now;
    m.locked_mask = locked_now;
    return m;
  endfunction

  always @(posedge clk) begin : monitor
    masks_t want;
    if (rst) begin
      limits.on_limit = ON_LIMIT_RESET;
      limits.lockout = LOCKOUT_RESET;
      open_now = '0;
      locked_now = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        open_ticks[c] = '0;
        lock_ticks[c] = '0;
      end
      expected_masks.delete();
      outstanding = 0;
      errors = 0;
      lock_hits = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_masks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual valve %b locked %b",
                   $time, result.valve_mask, result.locked_mask);
          errors++;
        end else begin
          want = expected_masks.pop_front();
          if (result.valve_mask !== want.valve_mask) begin
            $display("%0t: valve_mask expected %b actual %b",
                     $time, want.valve_mask, result.valve_mask);
            errors++;
          end
          if (result.locked_mask !== want.locked_mask) begin
            $display("%0t: locked_mask expected %b actual %b",
                     $time, want.locked_mask, result.locked_mask);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ON_LIMIT: limits.on_limit = cfg_data;
          REG_LOCKOUT:  limits.lockout = cfg_data;
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        want = step_channels(tick.pressed_mask);
        expected_masks.push_back(want);
        if (want.locked_mask != '0) lock_hits++;
      end
      outstanding = expected_masks.size();
    end
  end

endmodule

// File: test/valve_max_on_time_lockout_tb.sv
// Testbench top for the valve on-time limiter: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps
module valve_max_on_time_lockout_tb
  import vmol_pkg::*;
;

  localparam int CHANNELS = 3;
  localparam int SOAK_TICKS = 20;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     errors;
  int                     outstanding;
  int                     lock_hits;
  int                     ticks_sent = 0;
  int                     settings_used = 1;
  bit                     idle_on = 1'b1;
  bit                     squeeze_req = 1'b0;

  vmol_tick_if #(.CHANNELS(CHANNELS)) tick_bus ();
  vmol_result_if #(.CHANNELS(CHANNELS)) result_bus ();

  valve_max_on_time_lockout #(.CHANNELS(CHANNELS)) dut (
    .clk,
    .rst,
    .tick_in(tick_bus),
    .result_out(result_bus),
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  vmol_result_check #(.CHANNELS(CHANNELS)) u_check (
    .clk,
    .rst,
    .tick(tick_bus),
    .result(result_bus),
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .errors,
    .outstanding,
    .lock_hits
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink_side
    int stall;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        result_bus.ready <= 1'b0;
        for (stall = 0; stall < 64; stall++) @(posedge clk);
      end
      result_bus.ready <= !idle_on || ($urandom_range(99) >= 17);
    end
  end

  task automatic send_tick(input logic [CHANNELS-1:0] pressed);
    while (idle_on && $urandom_range(99) < 17) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.pressed_mask <= pressed;
    do @(posedge clk); while (!tick_bus.ready);
    ticks_sent++;
  endtask

  task automatic set_limits(input count_t on_lim, input count_t lock_lim);
    cfg_we <= 1'b1;
    cfg_index <= REG_ON_LIMIT;
    cfg_data <= on_lim;
    @(posedge clk);
    cfg_index <= REG_LOCKOUT;
    cfg_data <= lock_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    tick_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // button holds of random length, with some noise ticks mixed in
  task automatic random_phase(input count_t on_lim, input count_t lock_lim, input int n);
    logic [CHANNELS-1:0] held;
    int flip_pct;
    held = '0;
    flip_pct = $urandom_range(40, 4);
    set_limits(on_lim, lock_lim);
    repeat (n) begin
      if ($urandom_range(99) < 10) begin
        send_tick(CHANNELS'($urandom));
      end else begin
        for (int c = 0; c < CHANNELS; c++)
          if ($urandom_range(99) < flip_pct) held[c] = ~held[c];
        send_tick(held);
      end
    end
    drain();
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_ON_LIMIT;
    cfg_data <= '0;
    tick_bus.valid <= 1'b0;
    tick_bus.pressed_mask <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset limits
    send_tick(3'b000);
    send_tick(3'b111);
    send_tick(3'b111);
    send_tick(3'b010);
    send_tick(3'b101);
    send_tick(3'b000);
    drain();

    // zero limits: one tick open, one tick locked
    set_limits(16'd0, 16'd0);
    send_tick(3'b111);
    send_tick(3'b111);
    send_tick(3'b111);
    send_tick(3'b111);
    send_tick(3'b000);
    send_tick(3'b011);
    drain();

    // release during lockout keeps the lock
    set_limits(16'd2, 16'd3);
    repeat (5) send_tick(3'b001);
    send_tick(3'b000);
    repeat (5) send_tick(3'b110);
    send_tick(3'b001);
    drain();

    // full-scale on limit: valve never forced closed while held
    set_limits(16'hFFFF, 16'd5);
    repeat (SOAK_TICKS) send_tick(3'b111);
    send_tick(3'b000);
    drain();

    // full-scale lockout: lockout never ends
    set_limits(16'd0, 16'hFFFF);
    send_tick(3'b111);
    send_tick(3'b111);
    repeat (SOAK_TICKS) send_tick(CHANNELS'($urandom));
    drain();

    random_phase(ON_LIMIT_RESET, LOCKOUT_RESET, 80);
    idle_on = 1'b0;
    squeeze_req = 1'b1;
    random_phase(16'd1, 16'd1, 90);
    idle_on = 1'b1;
    random_phase(16'd0, 16'd0, 80);
    random_phase(16'd3, 16'd7, 80);
    random_phase(16'hFFFF, 16'd0, 80);
    random_phase(16'd0, 16'hFFFF, 80);
    random_phase(count_t'($urandom_range(9)), count_t'($urandom_range(12)), 80);
    random_phase(count_t'($urandom_range(9)), count_t'($urandom_range(12)), 80);
    random_phase(count_t'($urandom), count_t'($urandom), 40);

    repeat (8) @(posedge clk);
    $display("Sent %0d ticks under %0d limit settings; %0d results showed a lockout.",
             ticks_sent, settings_used, lock_hits);
    $display("Covered zero and full-scale limits, random button holds and a stalled output.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
